FILE: rtl/core/efsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efsd_pkg;

    localparam logic [7:0] CH_BACKSLASH      = 8'h5C;
    localparam logic [7:0] CH_ZERO           = 8'h30;
    localparam logic [7:0] CH_PERCENT        = 8'h25;
    localparam logic [7:0] CH_PLUS           = 8'h2B;
    localparam logic [7:0] CH_MINUS          = 8'h2D;
    localparam logic [7:0] CH_SPACE          = 8'h20;
    localparam logic [7:0] DELIM_RESET       = 8'h7C;
    localparam logic [1:0] CNT_ONE           = 2'd1;
    localparam logic [1:0] CNT_MAX           = 2'd2;

    // percent decoder phase; code 3 never occurs and decodes as text
    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    typedef struct packed {
        logic       bs_pending;
        phase_t     phase;
        logic [1:0] char_cnt;
        logic [7:0] hex_first;
    } dec_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       has_byte;
        logic       field_end;
    } dec_result_t;

    // {is_hex, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // two digits after '%', read base 16 with strtol rules, modulo 256
    function automatic logic [7:0] read_two(input logic [7:0] c1, input logic [7:0] c2);
        logic [4:0] v1;
        logic [4:0] v2;
        logic [7:0] r;
        v1 = hex_val(c1);
        v2 = hex_val(c2);
        r  = 8'd0;
        if (is_space(c1) || c1 == CH_PLUS) begin
            r = v2[4] ? {4'd0, v2[3:0]} : 8'd0;
        end else if (c1 == CH_MINUS) begin
            r = v2[4] ? 8'(8'd0 - {4'd0, v2[3:0]}) : 8'd0;
        end else if (v1[4]) begin
            r = v2[4] ? {v1[3:0], v2[3:0]} : {4'd0, v1[3:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/escaped_field_stream_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Escaped field stream decoder.
// s_ channel: one raw message byte per beat (s_in_byte), s_msg_end on the
//   last byte of a message. m_ channel: decoded field bytes; m_field_end
//   closes a field, m_has_byte = 0 marks a bare field end (m_out_byte = 0).
//   m_run_last is always 1: each input beat yields zero or one result.
// cfg_ channel: writes the delimiter byte (reset 0x7C '|'); write only while
//   idle. cfg_ready is always high.
// Path: a byte accepted into the input register is decoded by the step
//   logic and lands in the result register once the result slot is free.
// Throughput: one input beat per cycle while m_ready is high, one result
//   beat per cycle, set by the input register -> step logic -> result register path.
// Reset (aresetn low, synchronous): both registers empty, decoder state
//   cleared, delimiter back to '|'.
// Stall: while m_ready is low with a result held, the input register holds
//   its byte and s_ready drops once it is full; nothing is lost.
module escaped_field_stream_decoder_top import efsd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_msg_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_has_byte,
    output logic            m_field_end,
    output logic            m_run_last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic [7:0]  delim_reg;
    dec_state_t  st_reg;
    dec_state_t  st_next;
    dec_result_t res;
    logic        out_free;
    logic        advance;

    assign cfg_ready = 1'b1;

    // input register moves into the step logic when the result slot is free
    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            delim_reg    <= DELIM_RESET;
            st_reg       <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready) begin
                delim_reg <= cfg_data;
            end
            if (advance) begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_end_reg  <= s_msg_end;
        end
    end

    efsd_step u_step (
        .st        (st_reg),
        .delimiter (delim_reg),
        .in_byte   (in_byte_reg),
        .msg_end   (in_end_reg),
        .st_next   (st_next),
        .res       (res)
    );

    efsd_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .res         (res),
        .m_ready     (m_ready),
        .free        (out_free),
        .m_valid     (m_valid),
        .m_out_byte  (m_out_byte),
        .m_has_byte  (m_has_byte),
        .m_field_end (m_field_end),
        .m_run_last  (m_run_last)
    );

    // a bare result must close a field and carry a zero byte
    a_bare_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_field_end && m_out_byte == 8'd0)
        else $error("bare result without field end or with data");

    // end of message always leaves clean decoder state
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_end_reg |=> !st_reg.bs_pending && st_reg.phase == PH_TEXT
                                  && st_reg.char_cnt == 2'd0)
        else $error("decoder state carried past message end");

    // an item that ends a message always produces a closing result beat
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_end_reg |=> m_valid && m_field_end)
        else $error("message end without closing result");

    // the field byte count never exceeds its saturation point
    a_cnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.char_cnt != 2'd3)
        else $error("field byte count overflow");

endmodule

`default_nettype wire

FILE: rtl/core/efsd_step.sv
`timescale 1ns / 1ps
`default_nettype none

module efsd_step import efsd_pkg::*; (
    input  wire dec_state_t  st,
    input  wire logic [7:0]  delimiter,
    input  wire logic [7:0]  in_byte,
    input  wire logic        msg_end,
    output dec_state_t       st_next,
    output dec_result_t      res
);

    logic       got;
    logic       close;
    logic [7:0] emit;
    logic [4:0] hv;
    logic [4:0] hv_tail;

    assign hv = hex_val(st.hex_first);

    always_comb begin
        st_next = st;
        got     = 1'b0;
        close   = 1'b0;
        emit    = 8'd0;
        hv_tail = 5'd0;
        if (!st.bs_pending && in_byte == delimiter) begin
            // split: close the field with the old state
            if (st.phase == PH_PCT && st.char_cnt == CNT_ONE) begin
                emit = CH_PERCENT;
                got  = 1'b1;
            end else if (st.phase == PH_DIGIT) begin
                emit = hv[4] ? {4'd0, hv[3:0]} : 8'd0;
                got  = 1'b1;
            end
            st_next.phase      = PH_TEXT;
            st_next.char_cnt   = 2'd0;
            st_next.bs_pending = 1'b0;
            close = 1'b1;
        end else begin
            if (!st.bs_pending && in_byte == CH_BACKSLASH) begin
                st_next.bs_pending = 1'b1;
            end else if (st.bs_pending && in_byte == CH_ZERO) begin
                st_next.bs_pending = 1'b0;
            end else begin
                st_next.bs_pending = 1'b0;
                if (st.char_cnt != CNT_MAX) begin
                    st_next.char_cnt = st.char_cnt + 2'd1;
                end
                case (st.phase)
                    PH_PCT: begin
                        if (in_byte == CH_PERCENT) begin
                            st_next.phase = PH_TEXT;
                            emit = CH_PERCENT;
                            got  = 1'b1;
                        end else begin
                            st_next.hex_first = in_byte;
                            st_next.phase     = PH_DIGIT;
                        end
                    end
                    PH_DIGIT: begin
                        st_next.phase = PH_TEXT;
                        emit = read_two(st.hex_first, in_byte);
                        got  = 1'b1;
                    end
                    default: begin
                        if (in_byte == CH_PERCENT) begin
                            st_next.phase = PH_PCT;
                        end else begin
                            st_next.phase = PH_TEXT;
                            emit = in_byte;
                            got  = 1'b1;
                        end
                    end
                endcase
            end
            // end of message closes the field; a feed byte and a flush byte never coincide
            hv_tail = hex_val(st_next.hex_first);
            if (msg_end) begin
                if (st_next.phase == PH_PCT && st_next.char_cnt == CNT_ONE) begin
                    emit = CH_PERCENT;
                    got  = 1'b1;
                end else if (st_next.phase == PH_DIGIT) begin
                    emit = hv_tail[4] ? {4'd0, hv_tail[3:0]} : 8'd0;
                    got  = 1'b1;
                end
                close = 1'b1;
            end
        end
        if (msg_end) begin
            st_next.bs_pending = 1'b0;
            st_next.phase      = PH_TEXT;
            st_next.char_cnt   = 2'd0;
        end
        res.valid     = got || close;
        res.out_byte  = got ? emit : 8'd0;
        res.has_byte  = got;
        res.field_end = close;
    end

endmodule

`default_nettype wire

FILE: rtl/core/efsd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module efsd_out_reg import efsd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire dec_result_t res,
    input  wire logic        m_ready,
    output logic             free,
    output logic             m_valid,
    output logic [7:0]       m_out_byte,
    output logic             m_has_byte,
    output logic             m_field_end,
    output logic             m_run_last
);

    logic        valid_reg;
    logic        valid_next;
    dec_result_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (free) begin
            valid_next = load && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            data_reg <= res;
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = data_reg.out_byte;
    assign m_has_byte  = data_reg.has_byte;
    assign m_field_end = data_reg.field_end;
    assign m_run_last  = 1'b1;  // never more than one result per input beat

endmodule

`default_nettype wire

FILE: sim/tb_escaped_field_stream_decoder_top.sv
`timescale 1ns / 1ps

module tb_escaped_field_stream_decoder_top;
    import efsd_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int STALL_LIMIT   = 2000;  // cycles with no beat on any channel
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;     // covers the input and result registers plus margin

    // one decoded beat as the result channel should show it
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       closes;
    } field_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_msg_end;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_has_byte;
    logic       m_field_end;
    logic       m_run_last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    escaped_field_stream_decoder_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_msg_end   (s_msg_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_has_byte  (m_has_byte),
        .m_field_end (m_field_end),
        .m_run_last  (m_run_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder shadow state: splitter escape flag, percent decoder phase,
    // first hex digit and the saturating field length.
    // ------------------------------------------------------------------
    logic [7:0]  dlm       = DELIM_RESET;
    logic        esc_pend  = 1'b0;
    phase_t      phase     = PH_TEXT;
    logic [7:0]  hex_first = 8'd0;
    logic [1:0]  char_cnt  = 2'd0;

    field_beat_t expected_beats[$];
    logic [7:0]  msg_bytes[$];

    int fail_count    = 0;
    int stall_cycles  = 0;
    int rx_hold_left  = 0;
    int rx_gap_left   = 0;
    bit idle_on       = 1'b1;

    // hex digit value, -1 when the byte is no hex digit
    function automatic int nibble_of(input logic [7:0] c);
        case (c) inside
            [8'h30:8'h39]: return int'(c) - 'h30;
            [8'h41:8'h46]: return int'(c) - 'h41 + 10;
            [8'h61:8'h66]: return int'(c) - 'h61 + 10;
            default:       return -1;
        endcase
    endfunction

    // two bytes after '%' read like strtol base 16, kept mod 256
    function automatic logic [7:0] strtol_pair(input logic [7:0] c1, input logic [7:0] c2);
        int v1;
        int v2;
        v1 = nibble_of(c1);
        v2 = nibble_of(c2);
        if (c1 == CH_SPACE || (c1 >= 8'h09 && c1 <= 8'h0D) || c1 == CH_PLUS)
            return (v2 >= 0) ? 8'(v2) : 8'd0;
        if (c1 == CH_MINUS)
            return (v2 >= 0) ? 8'(0 - v2) : 8'd0;
        if (v1 >= 0)
            return (v2 >= 0) ? 8'(v1 * 16 + v2) : 8'(v1);
        return 8'd0;
    endfunction

    // one literal field byte into the percent decoder; 1 if a byte comes out
    function automatic logic percent_feed(input logic [7:0] c, output logic [7:0] dec);
        dec = 8'd0;
        if (char_cnt < CNT_MAX) char_cnt = char_cnt + 2'd1;
        case (phase)
            PH_PCT: begin
                if (c == CH_PERCENT) begin
                    phase = PH_TEXT;
                    dec   = CH_PERCENT;
                    return 1'b1;
                end
                hex_first = c;
                phase     = PH_DIGIT;
                return 1'b0;
            end
            PH_DIGIT: begin
                phase = PH_TEXT;
                dec   = strtol_pair(hex_first, c);
                return 1'b1;
            end
            default: begin
                if (c == CH_PERCENT) begin
                    phase = PH_PCT;
                    return 1'b0;
                end
                phase = PH_TEXT;
                dec   = c;
                return 1'b1;
            end
        endcase
    endfunction

    // field close: pending lone '%' survives only in a one-byte field,
    // a pending single digit is read alone
    function automatic logic close_field(output logic [7:0] dec);
        logic got;
        int   nib;
        got = 1'b0;
        dec = 8'd0;
        if (phase == PH_PCT && char_cnt == CNT_ONE) begin
            dec = CH_PERCENT;
            got = 1'b1;
        end else if (phase == PH_DIGIT) begin
            nib = nibble_of(hex_first);
            dec = (nib >= 0) ? 8'(nib) : 8'd0;
            got = 1'b1;
        end
        phase    = PH_TEXT;
        char_cnt = 2'd0;
        esc_pend = 1'b0;
        return got;
    endfunction

    // advance the shadow state by one accepted input beat
    function automatic void predict_beat(input logic [7:0] b, input logic last);
        logic        got;
        logic        closes;
        logic [7:0]  dec;
        logic [7:0]  tail;
        field_beat_t exp_beat;
        got    = 1'b0;
        closes = 1'b0;
        dec    = 8'd0;
        // delimiter check wins over the escape, even when it is a backslash
        if (!esc_pend && b == dlm) begin
            got    = close_field(dec);
            closes = 1'b1;
        end else begin
            if (!esc_pend && b == CH_BACKSLASH) begin
                esc_pend = 1'b1;
            end else if (esc_pend && b == CH_ZERO) begin
                esc_pend = 1'b0;   // escaped zero: empty-field marker, adds nothing
            end else begin
                esc_pend = 1'b0;
                got      = percent_feed(b, dec);
            end
            if (last) begin
                if (close_field(tail)) begin
                    dec = tail;
                    got = 1'b1;
                end
                closes = 1'b1;
            end
        end
        // nothing carries across a message boundary
        if (last) begin
            esc_pend = 1'b0;
            phase    = PH_TEXT;
            char_cnt = 2'd0;
        end
        if (got || closes) begin
            exp_beat.data     = got ? dec : 8'd0;
            exp_beat.has_data = got;
            exp_beat.closes   = closes;
            expected_beats    = {expected_beats, exp_beat};
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every m_ beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        field_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got byte %02h has %0b end %0b",
                         $time, m_out_byte, m_has_byte, m_field_end);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (m_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, m_out_byte);
                    fail_count++;
                end
                if (m_has_byte !== want.has_data) begin
                    $display("%0t: has_byte expected %0b actual %0b",
                             $time, want.has_data, m_has_byte);
                    fail_count++;
                end
                if (m_field_end !== want.closes) begin
                    $display("%0t: field_end expected %0b actual %0b",
                             $time, want.closes, m_field_end);
                    fail_count++;
                end
                // at most one result per input beat, so it is always the last
                if (m_run_last !== 1'b1) begin
                    $display("%0t: run_last expected 1 actual %0b", $time, m_run_last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a run of cycles with no beat on any channel means a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_escaped_field_stream_decoder_top NOT OK");
                $finish;
            end
        end
    end

    // Receiver: long hold-off on request, else random stall bursts
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_ready     <= 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end else if (rx_gap_left > 0) begin
                m_ready    <= 1'b0;
                rx_gap_left = rx_gap_left - 1;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                m_ready    <= 1'b0;
                rx_gap_left = $urandom_range(1, 8) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side; every task starts and ends at a falling edge
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_msg_end <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_beat(b, last);
        @(negedge aclk);
    endtask

    task automatic send_message(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], i == txt.len() - 1);
    endtask

    // let the block run dry: all results seen, then the pipe flushed of
    // beats that produce nothing
    task automatic drain_block();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_delimiter(input logic [7:0] v);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        dlm = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char();
        case ($urandom_range(0, 2))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h41 + 8'($urandom_range(0, 5));
            default: return 8'h61 + 8'($urandom_range(0, 5));
        endcase
    endfunction

    // byte biased toward the values the decoder treats specially
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0:       return dlm;
            1:       return CH_BACKSLASH;
            2:       return CH_PERCENT;
            3:       return hex_char();
            4:       return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
            5:       return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        msg_bytes = {msg_bytes, b};
    endfunction

    // mostly well-formed pieces: escapes, %%, %XY; some junk mixed in
    function automatic void add_token();
        case ($urandom_range(0, 9))
            0, 1: append_byte(noise_byte());
            2:    append_byte(dlm);
            3: begin
                append_byte(CH_BACKSLASH);
                append_byte(noise_byte());
            end
            4: begin
                append_byte(CH_BACKSLASH);
                append_byte(CH_ZERO);
            end
            5: begin
                append_byte(CH_PERCENT);
                append_byte(CH_PERCENT);
            end
            6, 7: begin
                append_byte(CH_PERCENT);
                append_byte(hex_char());
                append_byte(hex_char());
            end
            8: begin
                append_byte(CH_PERCENT);
                append_byte(noise_byte());
                append_byte(noise_byte());
            end
            default: begin
                append_byte(CH_PERCENT);
                append_byte(hex_char());
            end
        endcase
    endfunction

    task automatic send_random_messages(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            msg_bytes.delete();
            repeat ($urandom_range(1, 6)) add_token();
            foreach (msg_bytes[i])
                send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
            sent += msg_bytes.size();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // hand-picked messages under the reset delimiter '|'
    task automatic test_directed_messages();
        send_message("|%4");        // leading delimiter; "%4" read alone at field end
        send_message("%|a%%%|");    // lone '%' kept in 1-byte field, dropped after "a%%"
        send_message("\\0||\\|\\"); // escaped-zero empty field, double and escaped
                                    // delimiter, backslash as last byte
        send_message("%-1%4g");     // negative digit wraps; digit then non-hex
        send_message("% a%+z");     // leading space; sign with no digit
        send_byte(8'h00, 1'b0);     // field extremes
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_default_delimiter();
        send_random_messages(200);
    endtask

    // extremes plus the bytes that collide with escape, percent and digit
    task automatic test_delimiter_sweep();
        logic [7:0] sweep[6];
        sweep = '{8'h00, 8'hFF, CH_BACKSLASH, CH_PERCENT, CH_ZERO, 8'($urandom_range(0, 255))};
        foreach (sweep[i]) begin
            write_delimiter(sweep[i]);
            send_random_messages(120);
        end
    endtask

    // receiver stops for a long time while the sender keeps offering beats
    task automatic test_output_backpressure();
        write_delimiter(DELIM_RESET);
        rx_hold_left = HOLD_CYCLES;
        send_random_messages(60);
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate();
        drain_block();
        idle_on = 1'b0;
        send_random_messages(150);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_in_byte = 8'd0;
        s_msg_end = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 8'd0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_messages();
        test_default_delimiter();
        test_delimiter_sweep();
        test_output_backpressure();
        test_full_rate();

        drain_block();
        if (fail_count == 0)
            $display("tb_escaped_field_stream_decoder_top OK");
        else
            $display("tb_escaped_field_stream_decoder_top NOT OK");
        $finish;
    end

endmodule

FILE: escaped_field_stream_decoder_top.f
rtl/core/efsd_pkg.sv
rtl/core/efsd_step.sv
rtl/core/efsd_out_reg.sv
rtl/core/escaped_field_stream_decoder_top.sv
sim/tb_escaped_field_stream_decoder_top.sv
